// ===== sv/button_click_gesture_detector_unit_assert.svh =====
// ----------------------------------------------------------------------------
// button_click_gesture_detector_unit_assert
// Assertion macros used by the gesture detector checker.
// ----------------------------------------------------------------------------
`ifndef BUTTON_CLICK_GESTURE_DETECTOR_UNIT_ASSERT_SVH
`define BUTTON_CLICK_GESTURE_DETECTOR_UNIT_ASSERT_SVH

// same-cycle implication
`define BCGD_ASSERT_SAME(lbl, clk, dis, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (dis) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define BCGD_ASSERT_NEXT(lbl, clk, dis, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (dis) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/bcgd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcgd_pkg
// Types, constants and helpers of the button gesture detector.
// ----------------------------------------------------------------------------
package bcgd_pkg;

  localparam int CNT_W      = 16;
  localparam int TICK_W     = 16;
  localparam int CMP_W      = (CNT_W > TICK_W) ? CNT_W : TICK_W;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int FLAG_W     = 7;

  typedef logic [CNT_W-1:0]  cnt_t;
  typedef logic [TICK_W-1:0] tick_t;
  typedef logic [FLAG_W-1:0] flags_t;

  localparam cnt_t CNT_MAX = '1;

  // event flag bit positions
  localparam int F_CLICK  = 0;
  localparam int F_DBL    = 1;
  localparam int F_LONG   = 2;
  localparam int F_CLK_P  = 3;
  localparam int F_LONG_P = 4;
  localparam int F_DBL_P  = 5;
  localparam int F_REL_P  = 6;

  localparam flags_t FLAGS_RESET = flags_t'(1) << F_REL_P;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ACTIVE_LEVEL  = 3'd0,
    REG_DEBOUNCE      = 3'd1,
    REG_LONG_PRESS    = 3'd2,
    REG_DOUBLE_WINDOW = 3'd3,
    REG_CLICK_ONCE    = 3'd4,
    REG_LONG_ONCE     = 3'd5,
    REG_DOUBLE_ONCE   = 3'd6
  } cfg_reg_t;

  typedef struct packed {
    logic  active_level;
    tick_t debounce_ticks;
    tick_t long_press_ticks;
    tick_t double_click_window;
    logic  click_report_once;
    logic  long_report_once;
    logic  double_report_once;
  } cfg_t;

  typedef struct packed {
    logic clicked;
    logic long_clicked;
    logic double_clicked;
    logic released;
  } result_t;

  function automatic cnt_t sat_inc(input cnt_t v);
    return (v == CNT_MAX) ? v : v + cnt_t'(1);
  endfunction

endpackage

// ===== sv/bcgd_in_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcgd_in_if
// Poll tick request channel: one raw pin sample per request.
// ----------------------------------------------------------------------------
interface bcgd_in_if;
  logic valid;
  logic ready;
  logic pin_level;

  modport source (output valid, output pin_level, input ready);
  modport sink   (input valid, input pin_level, output ready);
endinterface

// ===== sv/bcgd_out_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcgd_out_if
// Gesture result channel: four query answers per request.
// ----------------------------------------------------------------------------
interface bcgd_out_if;
  logic valid;
  logic ready;
  logic clicked;
  logic long_clicked;
  logic double_clicked;
  logic released;

  modport source (output valid, output clicked, output long_clicked,
                  output double_clicked, output released, input ready);
  modport sink   (input valid, input clicked, input long_clicked,
                  input double_clicked, input released, output ready);
endinterface

// ===== sv/bcgd_cfg_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcgd_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface bcgd_cfg_if;
  import bcgd_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== sv/button_click_gesture_detector_unit.sv =====
`timescale 1ns / 1ps
// A request passes the input register and then the result register before its result can be accepted.
// Throughput: 1 request per cycle while the result channel is ready; the counter/flag update is combinational.
// The input stage keeps accepting while a result waits, until both registers are full.
// Reset (synchronous, rst_n low): counters cleared, release counter saturated,
// only the released-reported mark set, registers back to their defaults.
// ----------------------------------------------------------------------------
// button_click_gesture_detector_unit
// Debounced click, double click, long press and release detection per poll tick.
// ----------------------------------------------------------------------------
module button_click_gesture_detector_unit
  import bcgd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  bcgd_in_if.sink     in_ch,
  bcgd_out_if.source  out_ch,
  bcgd_cfg_if.sink    cfg_ch
);

  cfg_t cfg;
  logic s1_valid;
  logic s1_pin;
  logic s2_adv;

  bcgd_cfg_regs u_cfg (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .cfg_o  (cfg)
  );

  bcgd_in_stage u_in (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .adv_i   (s2_adv),
    .valid_o (s1_valid),
    .pin_o   (s1_pin)
  );

  bcgd_engine u_eng (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg_i   (cfg),
    .valid_i (s1_valid),
    .pin_i   (s1_pin),
    .adv_o   (s2_adv),
    .out_ch  (out_ch)
  );

endmodule

// ===== sv/bcgd_cfg_regs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcgd_cfg_regs
// Configuration register file; unknown indexes are dropped.
// ----------------------------------------------------------------------------
module bcgd_cfg_regs
  import bcgd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  bcgd_cfg_if.sink    cfg_ch,
  output cfg_t        cfg_o
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  assign cfg_ch.ready = 1'b1;
  assign cfg_o        = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_ch.valid) begin
      case (cfg_reg_t'(cfg_ch.index))
        REG_ACTIVE_LEVEL:  cfg_nxt.active_level        = cfg_ch.data[0];
        REG_DEBOUNCE:      cfg_nxt.debounce_ticks      = tick_t'(cfg_ch.data);
        REG_LONG_PRESS:    cfg_nxt.long_press_ticks    = tick_t'(cfg_ch.data);
        REG_DOUBLE_WINDOW: cfg_nxt.double_click_window = tick_t'(cfg_ch.data);
        REG_CLICK_ONCE:    cfg_nxt.click_report_once   = cfg_ch.data[0];
        REG_LONG_ONCE:     cfg_nxt.long_report_once    = cfg_ch.data[0];
        REG_DOUBLE_ONCE:   cfg_nxt.double_report_once  = cfg_ch.data[0];
        default:           cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.active_level        <= 1'b0;
      cfg_r.debounce_ticks      <= tick_t'(5);
      cfg_r.long_press_ticks    <= tick_t'(100);
      cfg_r.double_click_window <= tick_t'(30);
      cfg_r.click_report_once   <= 1'b1;
      cfg_r.long_report_once    <= 1'b1;
      cfg_r.double_report_once  <= 1'b1;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

// ===== sv/bcgd_in_stage.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcgd_in_stage
// Input register for the pin sample; refills when empty or whenever downstream advances.
// ----------------------------------------------------------------------------
module bcgd_in_stage
  import bcgd_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  bcgd_in_if.sink  in_ch,
  input  logic     adv_i,
  output logic     valid_o,
  output logic     pin_o
);

  logic valid_r;
  logic pin_r;
  logic load;

  assign load         = !valid_r || adv_i;
  assign in_ch.ready  = load;
  assign valid_o      = valid_r;
  assign pin_o        = pin_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load && in_ch.valid) begin
      pin_r <= in_ch.pin_level;
    end
  end

endmodule

// ===== sv/bcgd_engine.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcgd_engine
// Tick update of counters and event flags, query evaluation, result register.
// ----------------------------------------------------------------------------
module bcgd_engine
  import bcgd_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  cfg_t       cfg_i,
  input  logic       valid_i,
  input  logic       pin_i,
  output logic       adv_o,
  bcgd_out_if.source out_ch
);

  cnt_t    deb_r, deb_nxt;
  cnt_t    hold_r, hold_nxt;
  cnt_t    since_r, since_nxt;
  flags_t  flags_r, flags_nxt;
  logic    out_valid_r;
  result_t res_r, res_nxt;
  logic    adv;
  logic    pressed;
  logic    step;

  assign adv     = !out_valid_r || out_ch.ready;
  assign adv_o   = adv;
  assign step    = adv && valid_i;
  assign pressed = (pin_i == cfg_i.active_level);

  always_comb begin
    deb_nxt   = deb_r;
    hold_nxt  = hold_r;
    since_nxt = since_r;
    flags_nxt = flags_r;
    res_nxt   = '0;

    if (!pressed) begin
      deb_nxt   = '0;
      hold_nxt  = '0;
      since_nxt = sat_inc(since_r);
      if (flags_r[F_CLICK]) begin
        flags_nxt = '0;
        since_nxt = '0;
      end
    end else begin
      if (CMP_W'(deb_r) >= CMP_W'(cfg_i.debounce_ticks)) begin
        flags_nxt[F_CLICK] = 1'b1;
        if (CMP_W'(since_r) < CMP_W'(cfg_i.double_click_window)) begin
          flags_nxt[F_DBL] = 1'b1;
        end
      end
      deb_nxt = sat_inc(deb_r);
      if (CMP_W'(hold_r) >= CMP_W'(cfg_i.long_press_ticks)) begin
        flags_nxt[F_LONG] = 1'b1;
      end
      hold_nxt = sat_inc(hold_r);
    end

    // queries in fixed order
    if (flags_nxt[F_CLICK] && !flags_nxt[F_CLK_P]) begin
      if (cfg_i.click_report_once) flags_nxt[F_CLK_P] = 1'b1;
      res_nxt.clicked = 1'b1;
    end
    if (flags_nxt[F_LONG] && !flags_nxt[F_LONG_P]) begin
      if (cfg_i.long_report_once) flags_nxt[F_LONG_P] = 1'b1;
      res_nxt.long_clicked = 1'b1;
    end
    if (flags_nxt[F_DBL] && !flags_nxt[F_DBL_P]) begin
      if (cfg_i.double_report_once) flags_nxt[F_DBL_P] = 1'b1;
      res_nxt.double_clicked = 1'b1;
    end
    if (flags_nxt == '0) begin
      flags_nxt[F_REL_P] = 1'b1;
      res_nxt.released   = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      deb_r       <= '0;
      hold_r      <= '0;
      since_r     <= CNT_MAX;
      flags_r     <= FLAGS_RESET;
      out_valid_r <= 1'b0;
    end else begin
      if (adv) begin
        out_valid_r <= valid_i;
      end
      if (step) begin
        deb_r   <= deb_nxt;
        hold_r  <= hold_nxt;
        since_r <= since_nxt;
        flags_r <= flags_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      res_r <= res_nxt;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.clicked        = res_r.clicked;
  assign out_ch.long_clicked   = res_r.long_clicked;
  assign out_ch.double_clicked = res_r.double_clicked;
  assign out_ch.released       = res_r.released;

endmodule

// ===== sv/bcgd_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcgd_checker
// Port-level checks of the gesture detector, bound to the top level.
// ----------------------------------------------------------------------------
`include "button_click_gesture_detector_unit_assert.svh"

module bcgd_checker (
  input logic clk,
  input logic rst_n,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic out_clicked,
  input logic out_long_clicked,
  input logic out_double_clicked,
  input logic out_released
);

  `BCGD_ASSERT_NEXT(a_out_hold, clk, !rst_n, out_valid && !out_ready,
    out_valid && $stable({out_clicked, out_long_clicked, out_double_clicked, out_released}),
    "stalled result changed")
  `BCGD_ASSERT_SAME(a_rel_alone, clk, !rst_n, out_valid && out_released,
    !out_clicked && !out_long_clicked && !out_double_clicked,
    "release reported with a gesture")
  `BCGD_ASSERT_NEXT(a_rst_empty, clk, 1'b0, !rst_n, !out_valid, "result valid after reset")
  `BCGD_ASSERT_SAME(a_ready_free, clk, !rst_n, !out_valid, in_ready,
    "input stalled with empty output")

endmodule

bind button_click_gesture_detector_unit bcgd_checker u_bcgd_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_ready           (in_ch.ready),
  .out_valid          (out_ch.valid),
  .out_ready          (out_ch.ready),
  .out_clicked        (out_ch.clicked),
  .out_long_clicked   (out_ch.long_clicked),
  .out_double_clicked (out_ch.double_clicked),
  .out_released       (out_ch.released)
);

// ===== tb/button_click_gesture_detector_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// button_click_gesture_detector_unit_tb
// Self-checking bench for the button gesture detector. Every poll tick sent
// in is run through a local model of the debounce, hold and release counters
// and the event flags. The four expected query answers are queued and
// compared with each result that leaves the block. Coverage comes from short
// directed sequences, a hold against maximum thresholds, the saturated release
// counter out of reset, and phases of random press/release gestures with
// random stalls on both channels in most of them.
// ----------------------------------------------------------------------------
module button_click_gesture_detector_unit_tb;
  import bcgd_pkg::*;

  // no register at this index
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

  class gesture_tracker;
    cfg_t    cfg;
    cnt_t    debounce_cnt;
    cnt_t    hold_cnt;
    cnt_t    since_rel_cnt;
    flags_t  flags;
    result_t expected_answers[$];
    int      errors;
    int      n_ticks, n_click, n_long, n_double, n_release;

    function void clear();
      cfg.active_level        = 1'b0;
      cfg.debounce_ticks      = 16'd5;
      cfg.long_press_ticks    = 16'd100;
      cfg.double_click_window = 16'd30;
      cfg.click_report_once   = 1'b1;
      cfg.long_report_once    = 1'b1;
      cfg.double_report_once  = 1'b1;
      debounce_cnt  = '0;
      hold_cnt      = '0;
      since_rel_cnt = '1;
      flags         = '0;
      flags[F_REL_P] = 1'b1;
    endfunction

    function cnt_t bump(cnt_t v);
      return (v == '1) ? v : v + 1'b1;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
      case (cfg_reg_t'(idx))
        REG_ACTIVE_LEVEL:  cfg.active_level        = value[0];
        REG_DEBOUNCE:      cfg.debounce_ticks      = value;
        REG_LONG_PRESS:    cfg.long_press_ticks    = value;
        REG_DOUBLE_WINDOW: cfg.double_click_window = value;
        REG_CLICK_ONCE:    cfg.click_report_once   = value[0];
        REG_LONG_ONCE:     cfg.long_report_once    = value[0];
        REG_DOUBLE_ONCE:   cfg.double_report_once  = value[0];
        default: ;
      endcase
    endfunction

    function void note_tick(logic pin);
      result_t r;
      r = '0;
      if (pin != cfg.active_level) begin
        debounce_cnt  = '0;
        hold_cnt      = '0;
        since_rel_cnt = bump(since_rel_cnt);
        if (flags[F_CLICK]) begin
          flags         = '0;
          since_rel_cnt = '0;
        end
      end else begin
        // thresholds compare against the count before this tick's increment
        if (debounce_cnt >= cfg.debounce_ticks) begin
          flags[F_CLICK] = 1'b1;
          if (since_rel_cnt < cfg.double_click_window) flags[F_DBL] = 1'b1;
        end
        debounce_cnt = bump(debounce_cnt);
        if (hold_cnt >= cfg.long_press_ticks) flags[F_LONG] = 1'b1;
        hold_cnt = bump(hold_cnt);
      end
      if (flags[F_CLICK] && !flags[F_CLK_P]) begin
        if (cfg.click_report_once) flags[F_CLK_P] = 1'b1;
        r.clicked = 1'b1;
      end
      if (flags[F_LONG] && !flags[F_LONG_P]) begin
        if (cfg.long_report_once) flags[F_LONG_P] = 1'b1;
        r.long_clicked = 1'b1;
      end
      if (flags[F_DBL] && !flags[F_DBL_P]) begin
        if (cfg.double_report_once) flags[F_DBL_P] = 1'b1;
        r.double_clicked = 1'b1;
      end
      if (flags == '0) begin
        flags[F_REL_P] = 1'b1;
        r.released = 1'b1;
      end
      n_ticks++;
      n_click   += r.clicked;
      n_long    += r.long_clicked;
      n_double  += r.double_clicked;
      n_release += r.released;
      expected_answers.push_back(r);
    endfunction

    function void compare_bit(string field, logic exp_v, logic act_v);
      if (exp_v !== act_v) begin
        $error("%s: expected %0b, got %0b", field, exp_v, act_v);
        errors++;
      end
    endfunction

    function void check_answers(result_t got);
      result_t exp_r;
      if (expected_answers.size() == 0) begin
        $error("result with no request outstanding: %b", got);
        errors++;
        return;
      end
      exp_r = expected_answers.pop_front();
      compare_bit("clicked", exp_r.clicked, got.clicked);
      compare_bit("long_clicked", exp_r.long_clicked, got.long_clicked);
      compare_bit("double_clicked", exp_r.double_clicked, got.double_clicked);
      compare_bit("released", exp_r.released, got.released);
    endfunction
  endclass

  logic clk   = 1'b0;
  logic rst_n = 1'b0;
  bit   idle_on = 1'b1;
  gesture_tracker sb;

  bcgd_in_if  in_ch();
  bcgd_out_if out_ch();
  bcgd_cfg_if cfg_ch();

  button_click_gesture_detector_unit dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  initial begin
    #2_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready)
      sb.check_answers(result_t'({out_ch.clicked, out_ch.long_clicked,
                                  out_ch.double_clicked, out_ch.released}));
  end

  initial begin
    while (!rst_n) @(posedge clk);
    forever begin
      if (idle_on && $urandom_range(0, 3) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 4)) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
    end
  end

  task automatic drive_tick(input logic pin);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.pin_level <= pin;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_tick(pin);
  endtask

  task automatic drive_pattern(input logic [15:0] bits, input int n);
    for (int i = n - 1; i >= 0; i--) drive_tick(bits[i]);
  endtask

  // leaves valid high; the caller lowers it once the burst of writes is done
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    sb.write_reg(idx, value);
  endtask

  task automatic set_config(input logic [15:0] act, deb, lng, win, c1, c2, c3);
    write_reg(REG_ACTIVE_LEVEL, act);
    write_reg(REG_DEBOUNCE, deb);
    write_reg(REG_LONG_PRESS, lng);
    write_reg(REG_DOUBLE_WINDOW, win);
    write_reg(REG_CLICK_ONCE, c1);
    write_reg(REG_LONG_ONCE, c2);
    write_reg(REG_DOUBLE_ONCE, c3);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (sb.expected_answers.size() != 0) @(posedge clk);
  endtask

  task automatic run_gestures(input int n);
    int   sent;
    int   kind;
    int   len;
    int   top;
    logic act;
    sent = 0;
    while (sent < n) begin
      act  = sb.cfg.active_level;
      kind = $urandom_range(0, 9);
      if (kind < 7) begin
        top = int'(sb.cfg.debounce_ticks) + int'(sb.cfg.long_press_ticks) + 4;
        len = $urandom_range(1, (top > 60) ? 60 : top);
        repeat (len) drive_tick(act);
        sent += len;
        top = int'(sb.cfg.double_click_window) + 4;
        len = $urandom_range(1, (top > 40) ? 40 : top);
        repeat (len) drive_tick(!act);
        sent += len;
      end else if (kind < 9) begin
        // contact bounce
        len = $urandom_range(1, 4);
        repeat (len) drive_tick(1'($urandom()));
        sent += len;
      end else begin
        // short press, at most just long enough to register
        len = $urandom_range(1, int'(sb.cfg.debounce_ticks) + 1);
        repeat (len) drive_tick(act);
        drive_tick(!act);
        sent += len + 1;
      end
    end
  endtask

  initial begin
    logic [15:0] deb, lng, win;
    sb = new();
    sb.clear();
    in_ch.valid     = 1'b0;
    in_ch.pin_level = 1'b0;
    out_ch.ready    = 1'b0;
    cfg_ch.valid    = 1'b0;
    cfg_ch.index    = '0;
    cfg_ch.data     = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // directed: instant debounce, short long-press, double click, unknown index
    write_reg(REG_UNUSED, 16'hA5A5);
    set_config(16'hFFFF, 16'd0, 16'd2, 16'd4, 16'h0001, 16'h0001, 16'h0001);
    drive_pattern(16'b00_1111_0_11_0, 10);
    drain();
    // report-once off: flags answer on every tick they stay set
    set_config(16'h0003, 16'd1, 16'd0, 16'd3, 16'hFFFE, 16'hFFFE, 16'hFFFE);
    drive_pattern(16'b111_0_111_0_1_0, 10);
    drain();

    // hold against maximum thresholds: nothing registers
    idle_on = 1'b0;
    set_config(16'h0000, 16'hFFFF, 16'hFFFF, 16'h0000, 16'h0001, 16'h0001, 16'h0001);
    repeat (40) drive_tick(1'b0);
    repeat (3) drive_tick(1'b1);
    drain();

    for (int p = 0; p < 6; p++) begin
      idle_on = (p < 5) && (p != 2);
      deb = 16'($urandom_range(0, 5));
      lng = 16'($urandom_range(0, 30));
      win = 16'($urandom_range(0, 15));
      if (p == 1) begin
        deb = '0;
        lng = '0;
        win = '0;
      end
      if (p == 2) win = 16'hFFFF;
      set_config(16'($urandom()), deb, lng, win,
                 16'($urandom()), 16'($urandom()), 16'($urandom()));
      run_gestures(220);
      drain();
    end

    repeat (8) @(posedge clk);
    if (sb.expected_answers.size() != 0) begin
      $error("%0d results never arrived", sb.expected_answers.size());
      sb.errors++;
    end
    $display("Run covered %0d poll ticks: %0d clicks, %0d long clicks, %0d double clicks,",
             sb.n_ticks, sb.n_click, sb.n_long, sb.n_double);
    $display("  %0d releases, with counter saturation and report-once on and off",
             sb.n_release);
    if (sb.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
